// File: design/assert_macros.svh
// assertion macros for the design files, included by the qualifier top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequence is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/wodq_pkg.sv
// types and constants of the warning on/off delay qualifier
package wodq_pkg;

    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [DELAY_W-1:0]   delay_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_STOP_HOLD = 2'd0;
    localparam cfg_idx_t CFG_ON_DELAY  = 2'd1;
    localparam cfg_idx_t CFG_OFF_DELAY = 2'd2;

    // reset values of the configuration registers
    localparam delay_t STOP_HOLD_RST = 16'd1000;
    localparam delay_t ON_DELAY_RST  = 16'd500;
    localparam delay_t OFF_DELAY_RST = 16'd1000;

    // qualifier timers and warning flag
    typedef struct packed {
        time_t stop_time;
        logic  stop_valid;
        time_t risk_time;
        logic  risk_valid;
        time_t clear_time;
        logic  clear_valid;
        time_t prev_time;
        logic  prev_valid;
        logic  warn;
    } qual_state_t;

    localparam qual_state_t QUAL_STATE_RST = '0;

endpackage

// File: design/warning_on_off_delay_qualifier.sv
// top level of the warning on/off delay qualifier
//
// usage
// - input channel (in_valid/in_ready) carries one update per transfer: a 32-bit
//   millisecond timestamp with its valid bit, three gate flags and the raw risk flag
// - output channel (out_valid/out_ready) returns one warning_active per update,
//   in update order
// - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes stop hold,
//   on delay and off delay; cfg_ready is always high, unknown indexes are dropped;
//   write only while no update is in flight
// - order: an update lands in the input register on its transfer, is evaluated
//   against the timers while it sits there and moves into the output register
//   once that register is free or being read
// - throughput: one update per cycle while out_ready is high; the timer update is a
//   single pass of three parallel 32-bit subtract/compares between input and output registers
// - stall: while out_ready is low the result is held; one more update is taken
//   into the input register, then in_ready drops until the output drains
// - reset: timers cleared, warning off, delays back to 1000/500/1000 ms, both
//   pipeline registers empty
module warning_on_off_delay_qualifier
(
    input  logic                 clk,
    input  logic                 rst_n,
    // update channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wodq_pkg::time_t      time_ms,
    input  logic                 time_valid,
    input  logic                 autonomous_mode,
    input  logic                 vehicle_stopped,
    input  logic                 data_fresh,
    input  logic                 risk_raw,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 warning_active,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  wodq_pkg::cfg_idx_t   cfg_index,
    input  wodq_pkg::delay_t     cfg_data
);
    import wodq_pkg::*;

    `include "assert_macros.svh"

    // configuration registers
    delay_t stop_hold_reg;
    delay_t on_delay_reg;
    delay_t off_delay_reg;

    // input register stage
    logic   s1_valid_reg;
    time_t  s1_time_reg;
    logic   s1_tvalid_reg;
    logic   s1_auto_reg;
    logic   s1_stopped_reg;
    logic   s1_fresh_reg;
    logic   s1_risk_reg;

    // qualifier state and result register
    qual_state_t state_reg;
    qual_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        warn_out_reg;
    logic        warn_out_next;

    logic        advance;

    // timer arithmetic
    time_t  stop_start;
    time_t  risk_start;
    time_t  clear_start;
    time_t  stop_elapsed;
    time_t  risk_elapsed;
    time_t  clear_elapsed;
    logic   time_back;
    logic   gates_ok;

    // the evaluated update moves on whenever the output slot is free or being taken
    assign advance        = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !s1_valid_reg || advance;
    assign out_valid      = out_valid_reg;
    assign warning_active = warn_out_reg;
    assign cfg_ready      = 1'b1;
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_hold_reg <= STOP_HOLD_RST;
            on_delay_reg  <= ON_DELAY_RST;
            off_delay_reg <= OFF_DELAY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STOP_HOLD: stop_hold_reg <= cfg_data;
                CFG_ON_DELAY:  on_delay_reg  <= cfg_data;
                CFG_OFF_DELAY: off_delay_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // input register: control bit reset, payload only loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_time_reg    <= time_ms;
            s1_tvalid_reg  <= time_valid;
            s1_auto_reg    <= autonomous_mode;
            s1_stopped_reg <= vehicle_stopped;
            s1_fresh_reg   <= data_fresh;
            s1_risk_reg    <= risk_raw;
        end
    end

    // a timer that is not running starts at the current timestamp
    assign stop_start    = state_reg.stop_valid  ? state_reg.stop_time  : s1_time_reg;
    assign risk_start    = state_reg.risk_valid  ? state_reg.risk_time  : s1_time_reg;
    assign clear_start   = state_reg.clear_valid ? state_reg.clear_time : s1_time_reg;
    assign stop_elapsed  = s1_time_reg - stop_start;
    assign risk_elapsed  = s1_time_reg - risk_start;
    assign clear_elapsed = s1_time_reg - clear_start;
    assign time_back     = state_reg.prev_valid && (s1_time_reg < state_reg.prev_time);
    assign gates_ok      = s1_auto_reg && s1_stopped_reg && s1_fresh_reg;

    // qualifier update for the update in the input register
    always_comb
    begin
        state_next    = state_reg;
        warn_out_next = warn_out_reg;
        if (advance)
        begin
            if (!s1_tvalid_reg || time_back || !gates_ok)
            begin
                // bad time, time going backwards or a gate down: drop everything
                state_next    = QUAL_STATE_RST;
                warn_out_next = 1'b0;
            end
            else
            begin
                state_next.prev_time  = s1_time_reg;
                state_next.prev_valid = 1'b1;
                state_next.stop_time  = stop_start;
                state_next.stop_valid = 1'b1;
                if (stop_elapsed < {{(TIME_W-DELAY_W){1'b0}}, stop_hold_reg})
                begin
                    // still in the stop hold: risk and clear timers dropped, warning frozen
                    state_next.risk_valid  = 1'b0;
                    state_next.clear_valid = 1'b0;
                end
                else if (s1_risk_reg)
                begin
                    state_next.clear_valid = 1'b0;
                    state_next.risk_time   = risk_start;
                    state_next.risk_valid  = 1'b1;
                    if (risk_elapsed >= {{(TIME_W-DELAY_W){1'b0}}, on_delay_reg})
                    begin
                        state_next.warn = 1'b1;
                    end
                end
                else
                begin
                    state_next.risk_valid = 1'b0;
                    if (state_reg.warn)
                    begin
                        state_next.clear_time  = clear_start;
                        state_next.clear_valid = 1'b1;
                        if (clear_elapsed >= {{(TIME_W-DELAY_W){1'b0}}, off_delay_reg})
                        begin
                            state_next.warn        = 1'b0;
                            state_next.clear_valid = 1'b0;
                        end
                    end
                end
                warn_out_next = state_next.warn;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= QUAL_STATE_RST;
            out_valid_reg <= 1'b0;
            warn_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            warn_out_reg  <= warn_out_next;
        end
    end

    // an active warning needs a running stop timer and a known previous time
    `ASSERT_IMPL(a_warn_needs_stop, clk, rst_n, state_reg.warn,
        state_reg.stop_valid && state_reg.prev_valid, "warning on without stop timer")
    // the clear timer only runs while the warning is on
    `ASSERT_IMPL(a_clear_needs_warn, clk, rst_n, state_reg.clear_valid, state_reg.warn,
        "clear timer running with warning off")
    // risk and clear timers never run together
    `ASSERT_IMPL(a_timers_exclusive, clk, rst_n, state_reg.risk_valid,
        !state_reg.clear_valid, "risk and clear timers both running")
    // with the output slot free, an evaluated update always moves on
    `ASSERT_NEXT(a_no_bubble, clk, rst_n, s1_valid_reg && !out_valid_reg, out_valid_reg,
        "evaluated update not delivered")

endmodule
